### hw/rtl/pfla_pkg.sv
// Shared types and constants for the page free-list allocator.
// No dependencies; imported by pfla_link_ram and page_free_list_allocator.
`timescale 1ns / 1ps

package pfla_pkg;

    localparam int MAX_ORDER_BITS = 10;
    localparam int PAGE_BYTES     = 4096;
    localparam int POOL_PAGES     = (1 << MAX_ORDER_BITS) * 2;
    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
    localparam int PAGE_W         = $clog2(POOL_PAGES);
    localparam int PAGE_CNT_W     = PAGE_W + 1;
    localparam int LINK_W         = PAGE_W + 1;
    localparam int MEM_W          = 40;
    localparam int SIZE_W         = 32;
    localparam int ADDR_W         = 23;
    localparam int MODE_W         = 3;
    localparam int STATUS_W       = 2;

    localparam logic [MODE_W-1:0] MODE_INIT       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC_PAGE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FREE_PAGE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ALLOC_SIZE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FREE_ADDR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NULL  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [10:0]       page_index;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] byte_address;
    } pfla_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [10:0]         page_out;
        logic [ADDR_W-1:0]   address_out;
    } pfla_rsp_t;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] waddr;
        logic [LINK_W-1:0] wdata;
        logic [PAGE_W-1:0] raddr;
    } pfla_ram_req_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_INIT
    } pfla_state_t;

endpackage

### hw/rtl/pfla_link_ram.sv
// Next-link store: one write port, one read port, registered read data.
// Depends on pfla_pkg.
`timescale 1ns / 1ps

module pfla_link_ram (
    input  logic                         aclk,
    input  pfla_pkg::pfla_ram_req_t      ram_req,
    output logic [pfla_pkg::LINK_W-1:0]  rd_data
);
    import pfla_pkg::*;

    logic [LINK_W-1:0] mem [POOL_PAGES];
    logic [LINK_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ram_req.we) begin
            mem[ram_req.waddr] <= ram_req.wdata;
        end
        rd_data_reg <= mem[ram_req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/page_free_list_allocator.sv
// Top level of the page free-list allocator: control, head pointer, result register.
// Depends on pfla_pkg and pfla_link_ram.
//
// Usage:
//   s_valid/s_ready/s_data carry one request item (mode, page_index, size_bytes,
//   byte_address); m_valid/m_ready/m_data carry exactly one result item per request.
//   cfg_wr_en/cfg_wr_data write the memory size in bytes; write only while idle.
//   The result of an accepted request enters m_data from the EXEC state, when the
//   result register is free. s_ready is high only while idle, so no new request is
//   taken before the last has executed; idle covers the registered head-link read.
//   Init items return their result at once and then sweep the pool, writing one
//   link per cycle for each page of the pool (up to 2048 pages) with s_ready low.
//   Reset empties the list, zeroes the page count and the memory size; the link
//   memory is not cleared and is only read for pages that are on the list.
//   A stalled receiver holds the result in the output register; one further
//   request may be accepted and waits, not yet executed, until the register frees.
`timescale 1ns / 1ps

module page_free_list_allocator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [pfla_pkg::MEM_W-1:0]   cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  pfla_pkg::pfla_req_t          s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output pfla_pkg::pfla_rsp_t          m_data
);
    import pfla_pkg::*;

    pfla_state_t             state_reg, state_next;
    logic [MEM_W-1:0]        mem_size_reg;
    pfla_req_t               item_reg;
    logic [PAGE_W-1:0]       head_page_reg, head_page_next;
    logic                    head_valid_reg, head_valid_next;
    logic [PAGE_CNT_W-1:0]   pages_in_pool_reg, pages_in_pool_next;
    logic [PAGE_W-1:0]       init_cnt_reg, init_cnt_next;
    logic                    m_valid_reg, m_valid_next;
    pfla_rsp_t               m_data_reg, m_data_next;

    pfla_ram_req_t           ram_req;
    logic [LINK_W-1:0]       rd_data;

    logic                    out_free;
    logic [MEM_W-PAGE_SHIFT-1:0] pages_raw;
    logic [PAGE_CNT_W-1:0]   pool_cap;
    logic [PAGE_W-1:0]       addr_page;
    logic                    addr_page_ok;
    logic                    index_ok;
    logic                    init_last;

    pfla_link_ram u_link_ram (
        .aclk    (aclk),
        .ram_req (ram_req),
        .rd_data (rd_data)
    );

    assign out_free     = !m_valid_reg || m_ready;
    assign pages_raw    = mem_size_reg[MEM_W-1:PAGE_SHIFT];
    assign pool_cap     = (pages_raw > (MEM_W-PAGE_SHIFT)'(POOL_PAGES))
                          ? PAGE_CNT_W'(POOL_PAGES) : pages_raw[PAGE_CNT_W-1:0];
    assign addr_page    = item_reg.byte_address[PAGE_SHIFT +: PAGE_W];
    assign addr_page_ok = {1'b0, addr_page} < pages_in_pool_reg;
    assign index_ok     = {1'b0, item_reg.page_index} < pages_in_pool_reg;
    assign init_last    = {1'b0, init_cnt_reg} == (pages_in_pool_reg - PAGE_CNT_W'(1));

    assign s_ready = (state_reg == FSM_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= FSM_IDLE;
            mem_size_reg      <= '0;
            head_page_reg     <= '0;
            head_valid_reg    <= 1'b0;
            pages_in_pool_reg <= '0;
            init_cnt_reg      <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            head_page_reg     <= head_page_next;
            head_valid_reg    <= head_valid_next;
            pages_in_pool_reg <= pages_in_pool_next;
            init_cnt_reg      <= init_cnt_next;
            m_valid_reg       <= m_valid_next;
            if (cfg_wr_en) begin
                mem_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    always_comb begin
        pfla_rsp_t res;
        logic      do_pop;
        logic      do_push;
        logic [PAGE_W-1:0] push_page;

        res                = '0;
        do_pop             = 1'b0;
        do_push            = 1'b0;
        push_page          = '0;
        state_next         = state_reg;
        head_page_next     = head_page_reg;
        head_valid_next    = head_valid_reg;
        pages_in_pool_next = pages_in_pool_reg;
        init_cnt_next      = init_cnt_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_data_next        = m_data_reg;
        ram_req            = '0;
        ram_req.raddr      = head_page_reg;

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                    res.status = ST_OK;
                    unique case (item_reg.mode)
                        MODE_INIT: begin
                            pages_in_pool_next = pool_cap;
                            head_page_next     = '0;
                            head_valid_next    = 1'b0;
                            init_cnt_next      = '0;
                            if (pool_cap != '0) begin
                                state_next = FSM_INIT;
                            end
                        end
                        MODE_ALLOC_PAGE: begin
                            if (head_valid_reg) begin
                                do_pop = 1'b1;
                            end else begin
                                res.status = ST_NONE;
                            end
                        end
                        MODE_FREE_PAGE: begin
                            if (index_ok) begin
                                do_push   = 1'b1;
                                push_page = item_reg.page_index;
                            end else begin
                                res.status = ST_RANGE;
                            end
                        end
                        MODE_ALLOC_SIZE: begin
                            if (item_reg.size_bytes > SIZE_W'(PAGE_BYTES)) begin
                                res.status = ST_NONE;
                            end else if (!head_valid_reg) begin
                                res.status = ST_NONE;
                            end else begin
                                do_pop          = 1'b1;
                                res.address_out = ADDR_W'({head_page_reg,
                                                           {PAGE_SHIFT{1'b0}}});
                            end
                        end
                        MODE_FREE_ADDR: begin
                            if (item_reg.byte_address == '0) begin
                                res.status = ST_NULL;
                            end else if (addr_page_ok) begin
                                do_push   = 1'b1;
                                push_page = addr_page;
                            end else begin
                                res.status = ST_RANGE;
                            end
                        end
                        default: begin
                            res.status = ST_RANGE;
                        end
                    endcase
                    if (do_pop) begin
                        res.page_out    = head_page_reg;
                        head_valid_next = rd_data[LINK_W-1];
                        head_page_next  = rd_data[LINK_W-1] ? rd_data[PAGE_W-1:0] : '0;
                    end
                    if (do_push) begin
                        ram_req.we      = 1'b1;
                        ram_req.waddr   = push_page;
                        ram_req.wdata   = head_valid_reg ? {1'b1, head_page_reg} : '0;
                        head_page_next  = push_page;
                        head_valid_next = 1'b1;
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = res;
                end
            end
            FSM_INIT: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = init_cnt_reg;
                ram_req.wdata = (init_cnt_reg == '0)
                                ? '0 : {1'b1, init_cnt_reg - PAGE_W'(1)};
                if (init_last) begin
                    head_page_next  = init_cnt_reg;
                    head_valid_next = 1'b1;
                    state_next      = FSM_IDLE;
                end else begin
                    init_cnt_next = init_cnt_reg + PAGE_W'(1);
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    a_init_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_INIT |-> !s_ready)
        else $error("input accepted during init sweep");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == FSM_EXEC)
        else $error("accepted item did not enter execution");

    a_init_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_INIT |-> {1'b0, init_cnt_reg} < pages_in_pool_reg)
        else $error("init sweep beyond page count");

    a_pop_returns_head: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_EXEC && out_free && head_valid_reg
        && item_reg.mode == MODE_ALLOC_PAGE
        |=> m_valid && m_data.status == ST_OK
            && m_data.page_out == $past(head_page_reg))
        else $error("allocation did not return the list head");

    a_result_on_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_EXEC && out_free |=> m_valid && state_reg != FSM_EXEC)
        else $error("execution did not produce a result");

endmodule

### tb/page_free_list_allocator_tb.sv
// Self-checking testbench for page_free_list_allocator: queue-fed request driver,
// result monitor and an in-bench free-list predictor, across several memory sizes.
// Depends on pfla_pkg and the page_free_list_allocator RTL.
`timescale 1ns / 1ps

module page_free_list_allocator_tb;
    import pfla_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    localparam int LONG_HOLD      = 150;
    localparam int SWEEP_CYCLES   = POOL_PAGES + 16;
    localparam int QUIET_LIMIT    = 25000;
    localparam int ITEMS_PER_HALF = 70;
    localparam int ADDR_TOP       = (1 << ADDR_W) - 1;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [MEM_W-1:0]  cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    pfla_req_t         s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    pfla_rsp_t         m_data;

    page_free_list_allocator DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // free-list shadow
    logic [LINK_W-1:0]     link_of [POOL_PAGES];
    bit                    used_mark [POOL_PAGES];
    logic [PAGE_W-1:0]     head_pg  = '0;
    bit                    head_ok  = 1'b0;
    logic [PAGE_CNT_W-1:0] pool_cnt = '0;
    logic [MEM_W-1:0]      mem_bytes = '0;

    pfla_req_t req_queue[$];
    pfla_rsp_t rsp_due[$];

    int  n_issued  = 0;
    int  n_checked = 0;
    int  n_errors  = 0;
    int  n_sizes   = 0;
    int  tx_gap    = 0;
    int  rx_wait   = 0;
    int  hold_left = 0;
    int  hold_asks = 0;
    int  hold_done = 0;
    int  quiet     = 0;
    bit  tx_gappy  = 1'b0;
    bit  rx_gappy  = 1'b0;

    function automatic logic [PAGE_CNT_W-1:0] pages_for(logic [MEM_W-1:0] m);
        logic [MEM_W-1:0] q;
        q = m >> PAGE_SHIFT;
        return (q > POOL_PAGES) ? PAGE_CNT_W'(POOL_PAGES) : q[PAGE_CNT_W-1:0];
    endfunction

    function automatic void link_push(logic [PAGE_W-1:0] pg);
        used_mark[pg] = 1'b0;
        link_of[pg]   = head_ok ? {1'b1, head_pg} : '0;
        head_pg       = pg;
        head_ok       = 1'b1;
    endfunction

    function automatic bit link_pop(output logic [PAGE_W-1:0] pg);
        pg = '0;
        if (!head_ok) return 1'b0;
        pg            = head_pg;
        head_ok       = link_of[pg][PAGE_W];
        head_pg       = head_ok ? link_of[pg][PAGE_W-1:0] : '0;
        used_mark[pg] = 1'b1;
        return 1'b1;
    endfunction

    function automatic pfla_rsp_t free_list_answer(pfla_req_t r);
        pfla_rsp_t             a;
        logic [PAGE_W-1:0]     pg;
        logic [PAGE_CNT_W-1:0] n;
        a        = '0;
        a.status = ST_OK;
        case (r.mode)
            MODE_INIT: begin
                pool_cnt  = pages_for(mem_bytes);
                used_mark = '{default: 1'b0};
                head_ok   = 1'b0;
                head_pg   = '0;
                for (int i = 0; i < pool_cnt; i++) link_push(PAGE_W'(i));
            end
            MODE_ALLOC_PAGE: begin
                if (link_pop(pg)) a.page_out = pg;
                else a.status = ST_NONE;
            end
            MODE_FREE_PAGE: begin
                if (r.page_index >= pool_cnt) a.status = ST_RANGE;
                else link_push(r.page_index);
            end
            MODE_ALLOC_SIZE: begin
                if (r.size_bytes > PAGE_BYTES) begin
                    a.status = ST_NONE;
                end else if (!link_pop(pg)) begin
                    a.status = ST_NONE;
                end else begin
                    a.page_out    = pg;
                    a.address_out = ADDR_W'(pg) << PAGE_SHIFT;
                end
            end
            MODE_FREE_ADDR: begin
                n = PAGE_CNT_W'(r.byte_address >> PAGE_SHIFT);
                if (r.byte_address == '0) a.status = ST_NULL;
                else if (n >= pool_cnt) a.status = ST_RANGE;
                else link_push(n[PAGE_W-1:0]);
            end
            default: a.status = ST_RANGE;
        endcase
        return a;
    endfunction

    function automatic pfla_req_t request_of(logic [MODE_W-1:0] mode, logic [10:0] pg,
                                             logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ad);
        pfla_req_t r;
        r.mode         = mode;
        r.page_index   = pg;
        r.size_bytes   = sz;
        r.byte_address = ad;
        return r;
    endfunction

    function automatic pfla_req_t random_request(int pages);
        pfla_req_t r;
        int        pick;
        int        sub;
        r.mode         = MODE_ALLOC_PAGE;
        r.page_index   = 11'($urandom_range(0, POOL_PAGES - 1));
        r.size_bytes   = $urandom;
        r.byte_address = ADDR_W'($urandom_range(0, ADDR_TOP));
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        if (pick < 30) begin
            r.mode = MODE_ALLOC_PAGE;
        end else if (pick < 50) begin
            r.mode = MODE_ALLOC_SIZE;
            case (sub)
                0:       r.size_bytes = '0;
                1:       r.size_bytes = PAGE_BYTES;
                7:       r.size_bytes = PAGE_BYTES + 1;
                8, 9:    r.size_bytes = $urandom;
                default: r.size_bytes = $urandom_range(1, PAGE_BYTES);
            endcase
        end else if (pick < 68) begin
            r.mode = MODE_FREE_PAGE;
            if (pages > 0 && sub != 0) r.page_index = 11'($urandom_range(0, pages - 1));
        end else if (pick < 88) begin
            r.mode = MODE_FREE_ADDR;
            if (sub == 0) begin
                r.byte_address = '0;
            end else if (sub != 1 && pages > 0) begin
                r.byte_address = (ADDR_W'($urandom_range(0, pages - 1)) << PAGE_SHIFT)
                               | ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
            end
        end else if (pick < 92) begin
            r.mode = MODE_INIT;
        end else if (pick < 96) begin
            r.mode = MODE_SPARE_LO + MODE_W'($urandom_range(0, 2));
        end else begin
            r.mode = MODE_W'($urandom_range(0, 7));
        end
        return r;
    endfunction

    task automatic wait_for_drain();
        while (req_queue.size() != 0 || n_checked != n_issued) @(posedge aclk);
    endtask

    task automatic set_mem_size(logic [MEM_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        mem_bytes    = v;
        n_sizes++;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin : drive_requests
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) rsp_due.push_back(free_list_answer(s_data));
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    s_valid <= 1'b0;
                    tx_gap  <= tx_gap - 1;
                end else if (req_queue.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= req_queue.pop_front();
                    n_issued++;
                    tx_gap  <= tx_gappy ? $urandom_range(0, 12) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : drive_ready
        int w;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_wait   <= 0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_asks) begin
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= hold_done + 1;
        end else if (m_valid && m_ready) begin
            w = rx_gappy ? $urandom_range(0, 12) : 0;
            rx_wait <= w;
            m_ready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_ready <= (rx_wait == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        pfla_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (rsp_due.size() == 0) begin
                $error("unexpected result item: status %0d page_out %0d address_out 0x%0h",
                       m_data.status, m_data.page_out, m_data.address_out);
                n_errors++;
            end else begin
                want = rsp_due.pop_front();
                n_checked++;
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    n_errors++;
                end
                if (m_data.page_out !== want.page_out) begin
                    $error("page_out: expected %0d, got %0d", want.page_out, m_data.page_out);
                    n_errors++;
                end
                if (m_data.address_out !== want.address_out) begin
                    $error("address_out: expected 0x%0h, got 0x%0h",
                           want.address_out, m_data.address_out);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("page_free_list_allocator regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        logic [MEM_W-1:0] mem_list [8];
        int               pages;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // empty pool, null and spare modes
        set_mem_size('0);
        req_queue.push_back(request_of(MODE_ALLOC_PAGE, '0, '0, '0));
        req_queue.push_back(request_of(MODE_ALLOC_SIZE, '1, '0, '1));
        req_queue.push_back(request_of(MODE_FREE_PAGE, '0, '1, '0));
        req_queue.push_back(request_of(MODE_FREE_ADDR, '1, '1, '0));
        req_queue.push_back(request_of(MODE_FREE_ADDR, '0, '0, ADDR_W'(ADDR_TOP)));
        req_queue.push_back(request_of(MODE_SPARE_LO, '1, '1, '1));
        req_queue.push_back(request_of(MODE_SPARE_MID, '0, '0, '0));
        req_queue.push_back(request_of(MODE_SPARE_HI, '1, '0, '1));
        req_queue.push_back(request_of(MODE_INIT, '0, '0, '0));
        wait_for_drain();
        repeat (SWEEP_CYCLES) @(posedge aclk);

        // three-page pool: exhaustion, size limits, range edges, double free
        set_mem_size(MEM_W'(3 * PAGE_BYTES + PAGE_BYTES - 1));
        req_queue.push_back(request_of(MODE_INIT, '1, '1, '1));
        req_queue.push_back(request_of(MODE_ALLOC_PAGE, '0, '0, '0));
        req_queue.push_back(request_of(MODE_ALLOC_SIZE, '0, '0, '0));
        req_queue.push_back(request_of(MODE_ALLOC_SIZE, '0, PAGE_BYTES, '0));
        req_queue.push_back(request_of(MODE_ALLOC_PAGE, '0, '0, '0));
        req_queue.push_back(request_of(MODE_ALLOC_SIZE, '0, PAGE_BYTES + 1, '0));
        req_queue.push_back(request_of(MODE_FREE_PAGE, '1, '0, '0));
        req_queue.push_back(request_of(MODE_FREE_PAGE, 11'd2, '0, '0));
        req_queue.push_back(request_of(MODE_FREE_PAGE, 11'd2, '0, '0));
        req_queue.push_back(request_of(MODE_FREE_ADDR, '0, '0, ADDR_W'(3 * PAGE_BYTES)));
        req_queue.push_back(request_of(MODE_FREE_ADDR, '0, '0, ADDR_W'(2 * PAGE_BYTES - 1)));
        req_queue.push_back(request_of(MODE_ALLOC_SIZE, '0, '1, '0));
        req_queue.push_back(request_of(MODE_ALLOC_PAGE, '0, '0, '0));
        req_queue.push_back(request_of(MODE_ALLOC_PAGE, '0, '0, '0));
        req_queue.push_back(request_of(MODE_ALLOC_PAGE, '0, '0, '0));

        mem_list[0] = '1;
        mem_list[1] = MEM_W'(PAGE_BYTES);
        mem_list[2] = MEM_W'(16 * PAGE_BYTES);
        mem_list[3] = MEM_W'(PAGE_BYTES - 1);
        mem_list[4] = MEM_W'(POOL_PAGES * PAGE_BYTES);
        mem_list[5] = MEM_W'(64 * PAGE_BYTES + PAGE_BYTES - 1);
        mem_list[6] = MEM_W'({$urandom, $urandom});
        mem_list[7] = MEM_W'($urandom_range(0, 300 * PAGE_BYTES));

        foreach (mem_list[p]) begin
            wait_for_drain();
            repeat (SWEEP_CYCLES) @(posedge aclk);
            set_mem_size(mem_list[p]);
            pages    = int'(pages_for(mem_list[p]));
            tx_gappy = (p % 3 != 0);
            rx_gappy = (p % 2 == 0);
            req_queue.push_back(request_of(MODE_INIT, '0, '0, '0));
            for (int k = 0; k < ITEMS_PER_HALF - 1; k++)
                req_queue.push_back(random_request(pages));
            wait_for_drain();
            for (int k = 0; k < ITEMS_PER_HALF; k++)
                req_queue.push_back(random_request(pages));
            if (p == 0 || p == 5) hold_asks++;
        end

        wait_for_drain();
        repeat (SWEEP_CYCLES) @(posedge aclk);
        while (rsp_due.size() != 0) begin
            $error("result never arrived: status %0d page_out %0d",
                   rsp_due[0].status, rsp_due[0].page_out);
            void'(rsp_due.pop_front());
            n_errors++;
        end

        $display("Sent %0d requests over %0d memory sizes, from an empty to a capped pool;",
                 n_issued, n_sizes);
        $display("checked %0d results, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("page_free_list_allocator regression: pass");
        end else begin
            $display("page_free_list_allocator regression: fail");
        end
        $finish;
    end

endmodule
